// File: rtl/glb_pkg.sv
// Shared types and constants for the line blur: payload structs, tap register
// codes and the control structs passed between the sequencer and its datapath.
// No dependencies.
`default_nettype none

package glb_pkg;

    localparam int RADIUS_DEF = 7;      // default kernel radius
    localparam int NTAPS      = 8;      // center plus seven distance taps
    localparam int TAP_IDX_W  = $clog2(NTAPS);
    localparam int TAP_W      = 16;     // unsigned Q0.16 weight
    localparam int CH_W       = 8;
    localparam int NCH        = 4;      // alpha, red, green, blue
    localparam int PIX_W      = NCH * CH_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = TAP_W;

    // register indexes: center tap first, distance taps follow in order
    localparam logic [CFG_IDX_W-1:0] TAP_CENTER_IDX   = CFG_IDX_W'(0);
    localparam logic [TAP_W-1:0]     TAP_CENTER_RESET = 16'hFFFF;

    typedef struct packed {
        logic [CH_W-1:0] in_alpha;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic            last_in_line;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_alpha;
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            line_end;
    } pix_out_t;

    typedef struct packed {
        logic             clear;
        logic             en;
        logic [TAP_W-1:0] weight;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/glb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module glb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/glb_mac.sv
// Four-lane multiply-accumulate: one pixel beat times one tap weight per enabled cycle,
// plus the running weight sum. Depends on glb_pkg.
`default_nettype none

module glb_mac
    import glb_pkg::*;
#(
    parameter int ACC_W = 28,
    parameter int SUM_W = 20
) (
    input  wire logic                       clk,
    input  wire mac_ctl_t                   ctl,
    input  wire logic [PIX_W-1:0]           pix,
    output logic      [NCH-1:0][ACC_W-1:0]  acc,
    output logic      [SUM_W-1:0]           wsum
);

    logic [NCH-1:0][ACC_W-1:0]   acc_reg, acc_next;
    logic [SUM_W-1:0]            wsum_reg, wsum_next;
    logic [TAP_W+CH_W-1:0]       prod [NCH];

    always_comb
    begin
        acc_next  = acc_reg;
        wsum_next = wsum_reg;
        for (int c = 0; c < NCH; c++)
        begin
            prod[c] = ctl.weight * pix[PIX_W-1-CH_W*c -: CH_W];
        end
        if (ctl.clear)
        begin
            acc_next  = '0;
            wsum_next = '0;
        end
        else if (ctl.en)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                acc_next[c] = acc_reg[c] + ACC_W'(prod[c]);
            end
            wsum_next = wsum_reg + SUM_W'(ctl.weight);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        wsum_reg <= wsum_next;
    end

    assign acc  = acc_reg;
    assign wsum = wsum_reg;

endmodule

`default_nettype wire

// File: rtl/glb_div.sv
// Four-lane restoring divider sharing one divisor, one quotient bit per cycle.
// The quotient fits in one channel since each sum is at most 255 times the divisor.
// Depends on glb_pkg.
`default_nettype none

module glb_div
    import glb_pkg::*;
#(
    parameter int ACC_W = 28,
    parameter int SUM_W = 20
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [NCH-1:0][ACC_W-1:0]  dividend,
    input  wire logic [SUM_W-1:0]           divisor,
    output div_stat_t                       stat,
    output logic      [NCH-1:0][CH_W-1:0]   quot
);

    localparam int STEP_W = $clog2(CH_W);

    logic [NCH-1:0][ACC_W-1:0] rem_reg, rem_next;
    logic [NCH-1:0][CH_W-1:0]  q_reg, q_next;
    logic [ACC_W-1:0]          dsr_reg, dsr_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            q_next    = '0;
            dsr_next  = ACC_W'(divisor) << (CH_W - 1);
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                if (rem_reg[c] >= dsr_reg)
                begin
                    rem_next[c] = rem_reg[c] - dsr_reg;
                    q_next[c]   = {q_reg[c][CH_W-2:0], 1'b1};
                end
                else
                begin
                    q_next[c]   = {q_reg[c][CH_W-2:0], 1'b0};
                end
            end
            dsr_next  = dsr_reg >> 1;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

`default_nettype wire

// File: rtl/gaussian_line_blur_argb.sv
// Edge-normalized 1-D Gaussian blur over a line of ARGB pixels; the window is a
// circular buffer in one RAM, walked tap by tap through a shared MAC and divider.
// An item passes through accept, setup, L reads (L = taps inside the line, at most
// 2*RADIUS+1), drain, divide start, the divider and the result beat. A line end
// repeats setup to result per further result; a zero weight sum skips the divider.
// Input is taken only when idle. Reset clears sequencer and count; taps go to 65535, 0.
`default_nettype none

module gaussian_line_blur_argb
    import glb_pkg::*;
#(
    parameter int RADIUS = RADIUS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  src_valid,
    output logic                       src_ready,
    input  wire pix_in_t               src_data,
    output logic                       dst_valid,
    input  wire logic                  dst_ready,
    output pix_out_t                   dst_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int AW    = $clog2(WIN);
    localparam int CNT_W = $clog2(WIN + 1);
    localparam int SUM_W = TAP_W + $clog2(WIN);
    localparam int ACC_W = CH_W + SUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_DRAIN,
        S_DIV,
        S_WAIT,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic               flush_reg, flush_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [TAP_W-1:0]   rd_w_reg, rd_w_next;
    logic               rd_ctr_reg, rd_ctr_next;
    logic [PIX_W-1:0]   center_reg, center_next;
    pix_out_t           out_reg, out_next;
    logic [TAP_W-1:0]   taps_reg [NTAPS];

    logic               src_fire;
    logic [AW-1:0]      wp_inc;
    logic [CNT_W-1:0]   count_inc;
    logic [AW-1:0]      tap_gap;
    logic [TAP_W-1:0]   tap_w;
    logic [AW-1:0]      n_m1;
    logic [AW-1:0]      k_plus;
    logic [AW-1:0]      hi_calc;
    logic               last_out;
    logic [PIX_W-1:0]   ram_rdata;
    logic [PIX_W-1:0]   src_pix;

    mac_ctl_t                   mac_ctl;
    logic [NCH-1:0][ACC_W-1:0]  acc;
    logic [SUM_W-1:0]           wsum;
    logic                       div_start;
    div_stat_t                  div_stat;
    logic [NCH-1:0][CH_W-1:0]   quot;

    // age 0 is the newest pixel, stored at the write pointer
    function automatic logic [AW-1:0] age_addr(input logic [AW-1:0] wp,
                                               input logic [AW-1:0] age);
        logic [AW:0] wrap;
        wrap = (AW+1)'(wp) + (AW+1)'(WIN) - (AW+1)'(age);
        if (age <= wp)
        begin
            return wp - age;
        end
        return AW'(wrap);
    endfunction

    assign src_fire  = src_valid && src_ready;
    assign wp_inc    = (wp_reg == AW'(WIN - 1)) ? '0 : wp_reg + 1'b1;
    assign count_inc = (count_reg == CNT_W'(WIN)) ? count_reg : count_reg + 1'b1;
    assign src_pix   = {src_data.in_alpha, src_data.in_red,
                        src_data.in_green, src_data.in_blue};

    assign tap_gap = (idx_reg > k_reg) ? idx_reg - k_reg : k_reg - idx_reg;
    assign tap_w   = (int'(tap_gap) < NTAPS) ? taps_reg[TAP_IDX_W'(tap_gap)] : '0;

    assign n_m1    = AW'(count_reg - 1'b1);
    assign k_plus  = k_reg + AW'(RADIUS);
    assign hi_calc = (n_m1 < k_plus) ? n_m1 : k_plus;
    assign last_out = flush_reg && (k_reg == '0);

    assign mac_ctl.clear  = (state_reg == S_SETUP);
    assign mac_ctl.en     = rd_pend_reg;
    assign mac_ctl.weight = rd_w_reg;
    assign div_start      = (state_reg == S_DIV) && (wsum != '0);

    glb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (WIN)
    ) u_win (
        .clk   (clk),
        .we    (src_fire),
        .waddr (wp_inc),
        .wdata (src_pix),
        .re    (state_reg == S_READ),
        .raddr (age_addr(wp_reg, idx_reg)),
        .rdata (ram_rdata)
    );

    glb_mac #(
        .ACC_W (ACC_W),
        .SUM_W (SUM_W)
    ) u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .pix  (ram_rdata),
        .acc  (acc),
        .wsum (wsum)
    );

    glb_div #(
        .ACC_W (ACC_W),
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc),
        .divisor  (wsum),
        .stat     (div_stat),
        .quot     (quot)
    );

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        hi_next      = hi_reg;
        flush_next   = flush_reg;
        rd_pend_next = 1'b0;
        rd_w_next    = rd_w_reg;
        rd_ctr_next  = 1'b0;
        center_next  = center_reg;
        out_next     = out_reg;

        if (rd_pend_reg && rd_ctr_reg)
        begin
            center_next = ram_rdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (src_fire)
                begin
                    wp_next    = wp_inc;
                    count_next = count_inc;
                    if (src_data.last_in_line)
                    begin
                        flush_next = 1'b1;
                        k_next     = (count_inc > CNT_W'(RADIUS + 1)) ? AW'(RADIUS)
                                                                     : AW'(count_inc - 1'b1);
                        state_next = S_SETUP;
                    end
                    else if (count_inc >= CNT_W'(RADIUS + 1))
                    begin
                        flush_next = 1'b0;
                        k_next     = AW'(RADIUS);
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                idx_next   = '0;
                hi_next    = hi_calc;
                state_next = S_READ;
            end
            S_READ:
            begin
                rd_pend_next = 1'b1;
                rd_w_next    = tap_w;
                rd_ctr_next  = (idx_reg == k_reg);
                if (idx_reg == hi_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (wsum == '0)
                begin
                    // no weight left: pass the center pixel through
                    out_next.out_alpha = center_reg[PIX_W-1 -: CH_W];
                    out_next.out_red   = center_reg[PIX_W-1-CH_W -: CH_W];
                    out_next.out_green = center_reg[PIX_W-1-2*CH_W -: CH_W];
                    out_next.out_blue  = center_reg[CH_W-1:0];
                    out_next.line_end  = last_out;
                    state_next         = S_OUT;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    out_next.out_alpha = quot[0];
                    out_next.out_red   = quot[1];
                    out_next.out_green = quot[2];
                    out_next.out_blue  = quot[3];
                    out_next.line_end  = last_out;
                    state_next         = S_OUT;
                end
            end
            S_OUT:
            begin
                if (dst_ready)
                begin
                    if (flush_reg && (k_reg != '0))
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        // drop the line once its last beat is taken
                        if (flush_reg)
                        begin
                            count_next = '0;
                            flush_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            idx_reg     <= '0;
            hi_reg      <= '0;
            flush_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_w_reg    <= '0;
            rd_ctr_reg  <= 1'b0;
            center_reg  <= '0;
            out_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            idx_reg     <= idx_next;
            hi_reg      <= hi_next;
            flush_reg   <= flush_next;
            rd_pend_reg <= rd_pend_next;
            rd_w_reg    <= rd_w_next;
            rd_ctr_reg  <= rd_ctr_next;
            center_reg  <= center_next;
            out_reg     <= out_next;
        end
    end

    // tap registers; writes beyond the tap list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NTAPS; i++)
            begin
                taps_reg[i] <= (i == int'(TAP_CENTER_IDX)) ? TAP_CENTER_RESET : '0;
            end
        end
        else if (cfg_we && (int'(cfg_index) < NTAPS))
        begin
            taps_reg[TAP_IDX_W'(cfg_index)] <= cfg_data;
        end
    end

    assign src_ready = (state_reg == S_IDLE);
    assign dst_valid = (state_reg == S_OUT);
    assign dst_data  = out_reg;

endmodule

`default_nettype wire

// File: rtl/glb_checker.sv
// Port-level checks for the line blur, bound to the top level.
// Depends on glb_pkg and gaussian_line_blur_argb.
`default_nettype none

module glb_checker
    import glb_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     src_valid,
    input wire logic     src_ready,
    input wire pix_in_t  src_data,
    input wire logic     dst_valid,
    input wire logic     dst_ready,
    input wire pix_out_t dst_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
        else $error("result beat changed while stalled");

    // one item at a time: no input while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> !src_ready)
        else $error("input ready while a result is pending");

    // a line end always flushes at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready && src_data.last_in_line |=> !src_ready)
        else $error("line end accepted without a flush");

    // a result never shows up right after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> !dst_valid)
        else $error("result too soon after input beat");

endmodule

bind gaussian_line_blur_argb glb_checker u_glb_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for gaussian_line_blur_argb: random and directed ARGB lines
// under changing tap settings, with gaps and back-pressure on both channels.
// Depends on rtl/glb_pkg.sv and rtl/gaussian_line_blur_argb.sv.
`timescale 1ns / 1ps

module testbench;
    import glb_pkg::*;

    localparam int RADIUS          = RADIUS_DEF;
    localparam int WIN             = 2 * RADIUS + 1;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CFG_IDX_LAST    = 2 ** CFG_IDX_W - 1;

    typedef enum {
        SHAPE_FLAT_MAX,
        SHAPE_ZERO,
        SHAPE_GAUSS,
        SHAPE_RANDOM,
        SHAPE_FAR_ONLY,
        SHAPE_RESET
    } tap_shape_t;

    // Mirror of the blur: pixel window, line fill and taps, plus the queue of
    // blurred pixels still owed by the block.
    class blur_scoreboard;
        logic [PIX_W-1:0] window [WIN];
        int               fill;
        logic [TAP_W-1:0] weights [NTAPS];
        pix_out_t         blurred_q [$];
        int unsigned      errors;
        int unsigned      pixels_seen;
        int unsigned      results_checked;
        int unsigned      lines_closed;

        function new();
            foreach (window[i])
                window[i] = '0;
            fill = 0;
            weights[0] = TAP_CENTER_RESET;
            for (int i = 1; i < NTAPS; i++)
                weights[i] = '0;
            errors = 0;
            pixels_seen = 0;
            results_checked = 0;
            lines_closed = 0;
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction

        function void set_tap(int unsigned idx, logic [TAP_W-1:0] w);
            // writes past the last tap are dropped by the block
            if (idx < NTAPS)
                weights[idx] = w;
        endfunction

        function longint unsigned channel_of(logic [PIX_W-1:0] px, int c);
            return (px >> (PIX_W - CH_W * (c + 1))) & 8'hFF;
        endfunction

        // Blur the pixel at window age k with n pixels of the line present.
        function pix_out_t blur_at(int k, int n, bit last);
            longint unsigned acc [NCH];
            longint unsigned wsum;
            longint unsigned wt;
            logic [CH_W-1:0] ch [NCH];
            int              idx;
            int              tap_gap;
            pix_out_t        r;
            wsum = 0;
            foreach (acc[c])
                acc[c] = 0;
            for (int d = -RADIUS; d <= RADIUS; d++)
            begin
                idx = k + d;
                tap_gap = (d < 0) ? -d : d;
                if (idx >= 0 && idx < n && idx < WIN)
                begin
                    wt = (tap_gap < NTAPS) ? longint'(weights[tap_gap]) : 0;
                    for (int c = 0; c < NCH; c++)
                        acc[c] += wt * channel_of(window[idx], c);
                    wsum += wt;
                end
            end
            // no weight left inside the line: pass the center pixel through
            for (int c = 0; c < NCH; c++)
                ch[c] = (wsum == 0) ? CH_W'(channel_of(window[k], c)) : CH_W'(acc[c] / wsum);
            r.out_alpha = ch[0];
            r.out_red   = ch[1];
            r.out_green = ch[2];
            r.out_blue  = ch[3];
            r.line_end  = last;
            return r;
        endfunction

        function void note_pixel(pix_in_t p);
            int n;
            int k;
            for (int i = WIN - 1; i > 0; i--)
                window[i] = window[i - 1];
            window[0] = {p.in_alpha, p.in_red, p.in_green, p.in_blue};
            if (fill < WIN)
                fill++;
            n = fill;
            pixels_seen++;
            if (!p.last_in_line)
            begin
                if (n >= RADIUS + 1)
                    blurred_q.push_back(blur_at(RADIUS, n, 1'b0));
            end
            else
            begin
                // flush oldest first, then start a fresh line
                k = (n - 1 > RADIUS) ? RADIUS : n - 1;
                while (k >= 0)
                begin
                    blurred_q.push_back(blur_at(k, n, k == 0));
                    k--;
                end
                foreach (window[i])
                    window[i] = '0;
                fill = 0;
                lines_closed++;
            end
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            errors++;
            $display("mismatch %0d at %0t: %s got %0h want %0h", errors, $realtime, what,
                     got, want);
        endtask

        task check_pixel(pix_out_t got);
            pix_out_t want;
            results_checked++;
            if (blurred_q.size() == 0)
            begin
                report_mismatch("beat with nothing pending", got, 0);
                return;
            end
            want = blurred_q.pop_front();
            if (got.out_alpha !== want.out_alpha)
                report_mismatch("out_alpha", got.out_alpha, want.out_alpha);
            if (got.out_red !== want.out_red)
                report_mismatch("out_red", got.out_red, want.out_red);
            if (got.out_green !== want.out_green)
                report_mismatch("out_green", got.out_green, want.out_green);
            if (got.out_blue !== want.out_blue)
                report_mismatch("out_blue", got.out_blue, want.out_blue);
            if (got.line_end !== want.line_end)
                report_mismatch("line_end", got.line_end, want.line_end);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  src_valid;
    logic                  src_ready;
    pix_in_t               src_data;
    logic                  dst_valid;
    logic                  dst_ready;
    pix_out_t              dst_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blur_scoreboard   sb = new();
    logic [TAP_W-1:0] tap_plan [NTAPS];
    int               src_idle_pct;
    int               dst_stall_pct;
    bit               hold_off_req;
    int               hold_offs;
    int               settings_loaded;
    int unsigned      quiet_cycles;

    gaussian_line_blur_argb DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function pix_in_t make_pixel(logic [PIX_W-1:0] argb, bit last);
        pix_in_t p;
        {p.in_alpha, p.in_red, p.in_green, p.in_blue} = argb;
        p.last_in_line = last;
        return p;
    endfunction

    // Mostly random channels, with a bias toward the extremes.
    function pix_in_t random_pixel();
        logic [PIX_W-1:0] argb;
        argb = $urandom;
        for (int c = 0; c < NCH; c++)
        begin
            case ($urandom_range(0, 7))
                0: argb[PIX_W - CH_W * c - 1 -: CH_W] = '0;
                1: argb[PIX_W - CH_W * c - 1 -: CH_W] = '1;
                default: ;
            endcase
        end
        return make_pixel(argb, 1'b0);
    endfunction

    task send_pixel(pix_in_t p);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= p;
        do
            @(posedge clk);
        while (!src_ready);
        sb.note_pixel(p);
    endtask

    task release_source();
        @(negedge clk);
        src_valid <= 1'b0;
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        // let the sequencer settle before touching the taps
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task apply_taps(tap_shape_t shape);
        int               stray_idx;
        logic [TAP_W-1:0] stray_val;
        case (shape)
            SHAPE_FLAT_MAX:
                foreach (tap_plan[i])
                    tap_plan[i] = '1;
            SHAPE_ZERO:
                foreach (tap_plan[i])
                    tap_plan[i] = '0;
            SHAPE_GAUSS:
            begin
                tap_plan[0] = TAP_W'($urandom_range(16384, 65535));
                for (int i = 1; i < NTAPS; i++)
                    tap_plan[i] = TAP_W'((tap_plan[i - 1] * $urandom_range(40, 95)) / 100);
            end
            SHAPE_RANDOM:
                foreach (tap_plan[i])
                    tap_plan[i] = TAP_W'($urandom_range(0, 65535));
            SHAPE_FAR_ONLY:
            begin
                foreach (tap_plan[i])
                    tap_plan[i] = '0;
                tap_plan[NTAPS - 1] = TAP_W'($urandom_range(1, 65535));
            end
            default:
            begin
                foreach (tap_plan[i])
                    tap_plan[i] = '0;
                tap_plan[0] = TAP_CENTER_RESET;
            end
        endcase
        for (int i = 0; i < NTAPS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= TAP_CENTER_IDX + CFG_IDX_W'(i);
            cfg_data  <= tap_plan[i];
            @(posedge clk);
            sb.set_tap(i, tap_plan[i]);
        end
        // one write past the tap registers, which must leave them alone
        stray_idx = $urandom_range(NTAPS, CFG_IDX_LAST);
        stray_val = TAP_W'($urandom);
        @(negedge clk);
        cfg_index <= CFG_IDX_W'(stray_idx);
        cfg_data  <= stray_val;
        @(posedge clk);
        sb.set_tap(stray_idx, stray_val);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task run_phase(int src_pct, int dst_pct, int target, bit with_hold_off);
        int      sent;
        int      len;
        pix_in_t p;
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        sent = 0;
        while (sent < target)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 16);
            if (len > target - sent)
                len = target - sent;
            for (int i = 0; i < len; i++)
            begin
                p = random_pixel();
                p.last_in_line = (i == len - 1);
                if (with_hold_off && sent == 5)
                    hold_off_req = 1'b1;
                send_pixel(p);
                sent++;
            end
        end
        release_source();
        wait_drained();
    endtask

    // Receiver: random stalls, or one long hold-off on request.
    initial
    begin
        dst_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                dst_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
                hold_offs++;
            end
            else
                dst_ready <= rst_n && ($urandom_range(0, 99) >= dst_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
            sb.check_pixel(dst_data);
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && src_ready) || (dst_valid && dst_ready) || cfg_we)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.pending());
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        src_valid     = 1'b0;
        src_data      = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        hold_off_req  = 1'b0;
        hold_offs     = 0;
        settings_loaded = 0;
        quiet_cycles  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset taps: plain pass-through, one short line
        send_pixel(make_pixel(32'h00FF_00FF, 1'b0));
        send_pixel(make_pixel(32'hFF00_FF00, 1'b1));
        release_source();
        wait_drained();

        // all taps at full scale: single-pixel line, two-pixel line, bit patterns
        apply_taps(SHAPE_FLAT_MAX);
        send_pixel(make_pixel(32'hFFFF_FFFF, 1'b1));
        send_pixel(make_pixel(32'h0000_0000, 1'b0));
        send_pixel(make_pixel(32'hFFFF_FFFF, 1'b1));
        for (int i = 0; i < 16; i++)
        begin
            case (i % 4)
                0: send_pixel(make_pixel(32'hFFFF_FFFF, i == 15));
                1: send_pixel(make_pixel(32'h0000_0000, i == 15));
                2: send_pixel(make_pixel(32'hAA55_AA55, i == 15));
                default: send_pixel(make_pixel(32'h55AA_55AA, i == 15));
            endcase
        end
        release_source();
        wait_drained();

        // zero weight sum everywhere: every pixel passes through
        apply_taps(SHAPE_ZERO);
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        send_pixel(make_pixel(32'h1234_5678, 1'b1));
        release_source();
        wait_drained();

        apply_taps(SHAPE_GAUSS);
        run_phase(0, 0, 16, 1'b0);
        apply_taps(SHAPE_RANDOM);
        run_phase(46, 0, 16, 1'b0);
        // only the farthest tap: near the line ends the weight sum drops to zero
        apply_taps(SHAPE_FAR_ONLY);
        run_phase(0, 46, 16, 1'b1);
        apply_taps(SHAPE_GAUSS);
        run_phase(37, 37, 16, 1'b0);
        apply_taps(SHAPE_RESET);
        run_phase(37, 37, 12, 1'b0);

        if (sb.pending() != 0)
            sb.report_mismatch("results never delivered", sb.pending(), 0);
        $display("covered %0d pixels in %0d lines, %0d blurred pixels checked",
                 sb.pixels_seen, sb.lines_closed, sb.results_checked);
        $display("%0d tap settings, gaps and stalls on both sides, %0d long output hold-off",
                 settings_loaded, hold_offs);
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/glb_pkg.sv
rtl/glb_ram.sv
rtl/glb_mac.sv
rtl/glb_div.sv
rtl/gaussian_line_blur_argb.sv
rtl/glb_checker.sv
sim/testbench.sv
